/* rtl/ccc_pkg.sv */
// ============================================================================
// ccc_pkg: shared types and constants for the circle collision unit
// Field widths, pipeline stage counts and the sideband carried along the pipe.
// ============================================================================
`default_nettype none

package ccc_pkg;

    localparam int COORD_W      = 32;
    localparam int RADIUS_W     = 31;
    localparam int MAG_W        = 32;
    localparam int SQ_W         = 64;
    localparam int ROOT_W       = 32;
    localparam int DIR_W        = 16;

    localparam int FRONT_STAGES = 4;
    localparam int SQRT_STAGES  = ROOT_W;
    localparam int DIV_STAGES   = DIR_W + 1;
    localparam int LATENCY      = FRONT_STAGES + SQRT_STAGES + DIV_STAGES + 1;

    localparam int IN_DATA_W    = 256;
    localparam int OUT_DATA_W   = 56;

    localparam logic [DIR_W-1:0] DIR_MAX = {1'b0, {(DIR_W-1){1'b1}}};

    // per-item data that rides alongside the square root
    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  hit;
        logic                  nz;
    } t_side;

    // flags that ride alongside the divide lanes
    typedef struct packed {
        logic [2:0] neg;
        logic       hit;
        logic       nz;
    } t_flg;

endpackage

`default_nettype wire

/* rtl/ccc_front.sv */
// ============================================================================
// ccc_front: difference, magnitude, squares and hit compare
// Four register stages: centre difference, absolute value, squares, then the
// sum of squares against the squared radius sum.
// ============================================================================
`default_nettype none

module ccc_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic [ccc_pkg::COORD_W-1:0]    i_a_x,
    input  wire logic [ccc_pkg::COORD_W-1:0]    i_a_y,
    input  wire logic [ccc_pkg::COORD_W-1:0]    i_a_z,
    input  wire logic [ccc_pkg::RADIUS_W-1:0]   i_a_radius,
    input  wire logic [ccc_pkg::COORD_W-1:0]    i_b_x,
    input  wire logic [ccc_pkg::COORD_W-1:0]    i_b_y,
    input  wire logic [ccc_pkg::COORD_W-1:0]    i_b_z,
    input  wire logic [ccc_pkg::RADIUS_W-1:0]   i_b_radius,
    output      logic [ccc_pkg::SQ_W-1:0]       o_sum,
    output      ccc_pkg::t_side                 o_side
);

    logic [2:0][ccc_pkg::COORD_W:0]   r_d;
    logic [ccc_pkg::MAG_W-1:0]        r_rsum0;
    logic [2:0][ccc_pkg::MAG_W-1:0]   r_mag1;
    logic [2:0]                       r_neg1;
    logic [ccc_pkg::MAG_W-1:0]        r_rsum1;
    logic [2:0][ccc_pkg::MAG_W-1:0]   r_mag2;
    logic [2:0]                       r_neg2;
    logic [2:0][ccc_pkg::SQ_W-1:0]    r_sq2;
    logic [ccc_pkg::SQ_W-1:0]         r_r2;
    logic [ccc_pkg::SQ_W-1:0]         r_sum3;
    ccc_pkg::t_side                   r_side3;

    logic [2:0][ccc_pkg::COORD_W:0]   n_d;
    logic [2:0][ccc_pkg::MAG_W-1:0]   n_mag;
    logic [ccc_pkg::SQ_W+1:0]         n_sum;

    // form the centre difference with one guard bit
    always_comb begin
        n_d[0] = {i_a_x[ccc_pkg::COORD_W-1], i_a_x} - {i_b_x[ccc_pkg::COORD_W-1], i_b_x};
        n_d[1] = {i_a_y[ccc_pkg::COORD_W-1], i_a_y} - {i_b_y[ccc_pkg::COORD_W-1], i_b_y};
        n_d[2] = {i_a_z[ccc_pkg::COORD_W-1], i_a_z} - {i_b_z[ccc_pkg::COORD_W-1], i_b_z};
    end

    // take magnitudes; they always fit 32 bits
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mag[i] = r_d[i][ccc_pkg::COORD_W] ? ccc_pkg::MAG_W'(-r_d[i])
                                                : r_d[i][ccc_pkg::MAG_W-1:0];
        end
    end

    // add the three squares
    assign n_sum = {2'b00, r_sq2[0]} + {2'b00, r_sq2[1]} + {2'b00, r_sq2[2]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d      <= n_d;
            r_rsum0  <= {1'b0, i_a_radius} + {1'b0, i_b_radius};

            r_mag1   <= n_mag;
            for (int i = 0; i < 3; i++) begin
                r_neg1[i] <= r_d[i][ccc_pkg::COORD_W];
            end
            r_rsum1  <= r_rsum0;

            r_mag2   <= r_mag1;
            r_neg2   <= r_neg1;
            for (int i = 0; i < 3; i++) begin
                r_sq2[i] <= r_mag1[i] * r_mag1[i];
            end
            r_r2     <= r_rsum1 * r_rsum1;

            r_sum3        <= n_sum[ccc_pkg::SQ_W-1:0];
            r_side3.mag   <= r_mag2;
            r_side3.neg   <= r_neg2;
            r_side3.hit   <= (n_sum < {2'b00, r_r2});
            r_side3.nz    <= (n_sum != '0);
        end
    end

    assign o_sum  = r_sum3;
    assign o_side = r_side3;

endmodule

`default_nettype wire

/* rtl/ccc_sqrt.sv */
// ============================================================================
// ccc_sqrt: pipelined integer square root
// One result bit per stage, two radicand bits brought down each stage.
// ============================================================================
`default_nettype none

module ccc_sqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [ccc_pkg::SQ_W-1:0]      i_sum,
    input  wire ccc_pkg::t_side                i_side,
    output      logic [ccc_pkg::ROOT_W-1:0]    o_root,
    output      ccc_pkg::t_side                o_side
);

    localparam int N     = ccc_pkg::SQRT_STAGES;
    localparam int REM_W = ccc_pkg::ROOT_W + 3;

    logic [REM_W-1:0]           r_rem  [0:N-1];
    logic [ccc_pkg::ROOT_W-1:0] r_root [0:N-1];
    logic [ccc_pkg::SQ_W-1:0]   r_rad  [0:N-1];
    ccc_pkg::t_side             r_side [0:N-1];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_stage
            logic [REM_W-1:0]           w_rem;
            logic [ccc_pkg::ROOT_W-1:0] w_root;
            logic [ccc_pkg::SQ_W-1:0]   w_rad;
            ccc_pkg::t_side             w_side;
            logic [REM_W-1:0]           n_shift;
            logic [REM_W-1:0]           n_trial;
            logic                       n_ge;

            if (k == 0) begin : g_first
                assign w_rem  = '0;
                assign w_root = '0;
                assign w_rad  = i_sum;
                assign w_side = i_side;
            end else begin : g_next
                assign w_rem  = r_rem[k-1];
                assign w_root = r_root[k-1];
                assign w_rad  = r_rad[k-1];
                assign w_side = r_side[k-1];
            end

            // bring down two bits and try root*4+1
            assign n_shift = {w_rem[REM_W-3:0], w_rad[ccc_pkg::SQ_W-1 -: 2]};
            assign n_trial = {1'b0, w_root, 2'b01};
            assign n_ge    = (n_shift >= n_trial);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]  <= n_ge ? (n_shift - n_trial) : n_shift;
                    r_root[k] <= {w_root[ccc_pkg::ROOT_W-2:0], n_ge};
                    r_rad[k]  <= {w_rad[ccc_pkg::SQ_W-3:0], 2'b00};
                    r_side[k] <= w_side;
                end
            end
        end
    endgenerate

    assign o_root = r_root[N-1];
    assign o_side = r_side[N-1];

endmodule

`default_nettype wire

/* rtl/ccc_div.sv */
// ============================================================================
// ccc_div: pipelined rounded divide for one direction component
// Forms mag*2^15 + len/2, then restoring division, one quotient bit a stage.
// ============================================================================
`default_nettype none

module ccc_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [ccc_pkg::MAG_W-1:0]     i_mag,
    input  wire logic [ccc_pkg::ROOT_W-1:0]    i_len,
    output      logic [ccc_pkg::DIR_W-1:0]     o_quot
);

    localparam int N     = ccc_pkg::DIV_STAGES;
    localparam int Q_W   = ccc_pkg::DIR_W;
    localparam int NUM_W = ccc_pkg::MAG_W + Q_W;
    localparam int REM_W = ccc_pkg::ROOT_W;

    logic [REM_W-1:0]           r_rem [0:N-1];
    logic [Q_W-1:0]             r_low [0:N-1];
    logic [ccc_pkg::ROOT_W-1:0] r_len [0:N-1];

    logic [NUM_W-1:0]           n_num;

    // numerator with half the divisor added for rounding
    assign n_num = {1'b0, i_mag, {(Q_W-1){1'b0}}}
                 + {{(NUM_W-ccc_pkg::ROOT_W+1){1'b0}}, i_len[ccc_pkg::ROOT_W-1:1]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_num[NUM_W-1:Q_W];
            r_low[0] <= n_num[Q_W-1:0];
            r_len[0] <= i_len;
        end
    end

    genvar k;
    generate
        for (k = 1; k < N; k++) begin : g_step
            logic [REM_W:0] n_shift;
            logic           n_ge;
            logic [REM_W:0] n_diff;

            // shift in the next numerator bit and subtract when it fits
            assign n_shift = {r_rem[k-1], r_low[k-1][Q_W-1]};
            assign n_ge    = (n_shift >= {1'b0, r_len[k-1]});
            assign n_diff  = n_shift - {1'b0, r_len[k-1]};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_ge ? n_diff[REM_W-1:0] : n_shift[REM_W-1:0];
                    r_low[k] <= {r_low[k-1][Q_W-2:0], n_ge};
                    r_len[k] <= r_len[k-1];
                end
            end
        end
    endgenerate

    assign o_quot = r_low[N-1];

endmodule

`default_nettype wire

/* rtl/circle_circle_collision_unit.sv */
// Throughput: one pair per cycle while the output is not held; front end, 32-stage square
// root and 17-stage divide lanes all advance together on one shared enable.
// A held output stalls the whole pipeline; no item is lost or repeated.
// Reset (synchronous, active low) clears every stage valid bit.
// ============================================================================
// circle_circle_collision_unit: circle pair intersection test, streaming
// Reports overlap of two circles and the Q1.15 unit direction from b to a.
// ============================================================================
`default_nettype none

module circle_circle_collision_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output      logic                               s_axis_tready,
    // a_x, a_y, a_z, a_radius, b_x, b_y, b_z, b_radius, zero pad
    input  wire logic [ccc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output      logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // hit, dir_x, dir_y, dir_z, zero pad
    output      logic [ccc_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    localparam int DN = ccc_pkg::DIV_STAGES;

    logic                            w_en;
    logic [ccc_pkg::LATENCY-1:0]     r_vld;
    logic [ccc_pkg::SQ_W-1:0]        w_sum;
    ccc_pkg::t_side                  w_fside;
    logic [ccc_pkg::ROOT_W-1:0]      w_root;
    ccc_pkg::t_side                  w_sside;
    logic [2:0][ccc_pkg::DIR_W-1:0]  w_quot;
    ccc_pkg::t_flg                   r_flg [0:DN-1];
    logic [3*ccc_pkg::DIR_W:0]       r_out;
    logic [3*ccc_pkg::DIR_W:0]       n_out;

    // advance everything when the output slot is free or being taken
    assign w_en          = !r_vld[ccc_pkg::LATENCY-1] || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[ccc_pkg::LATENCY-2:0], s_axis_tvalid};
        end
    end

    ccc_front u_front (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_a_x      (s_axis_tdata[31:0]),
        .i_a_y      (s_axis_tdata[63:32]),
        .i_a_z      (s_axis_tdata[95:64]),
        .i_a_radius (s_axis_tdata[126:96]),
        .i_b_x      (s_axis_tdata[158:127]),
        .i_b_y      (s_axis_tdata[190:159]),
        .i_b_z      (s_axis_tdata[222:191]),
        .i_b_radius (s_axis_tdata[253:223]),
        .o_sum      (w_sum),
        .o_side     (w_fside)
    );

    ccc_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_sum  (w_sum),
        .i_side (w_fside),
        .o_root (w_root),
        .o_side (w_sside)
    );

    genvar c;
    generate
        for (c = 0; c < 3; c++) begin : g_lane
            ccc_div u_div (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_mag  (w_sside.mag[c]),
                .i_len  (w_root),
                .o_quot (w_quot[c])
            );
        end
    endgenerate

    // carry signs and hit flags beside the divide lanes
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_flg[0].neg <= w_sside.neg;
            r_flg[0].hit <= w_sside.hit;
            r_flg[0].nz  <= w_sside.nz;
            for (int i = 1; i < DN; i++) begin
                r_flg[i] <= r_flg[i-1];
            end
        end
    end

    // saturate, apply sign, zero on miss or coincident centres
    always_comb begin
        logic [ccc_pkg::DIR_W-1:0] m;
        n_out    = '0;
        n_out[0] = r_flg[DN-1].hit;
        for (int i = 0; i < 3; i++) begin
            m = w_quot[i][ccc_pkg::DIR_W-1] ? ccc_pkg::DIR_MAX : w_quot[i];
            if (r_flg[DN-1].hit && r_flg[DN-1].nz) begin
                n_out[1 + i*ccc_pkg::DIR_W +: ccc_pkg::DIR_W] =
                    r_flg[DN-1].neg[i] ? (~m + 1'b1) : m;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_vld[ccc_pkg::LATENCY-1];
    assign m_axis_tdata  = {{(ccc_pkg::OUT_DATA_W-3*ccc_pkg::DIR_W-1){1'b0}}, r_out};

endmodule

`default_nettype wire

/* rtl/ccc_checker.sv */
// ============================================================================
// ccc_checker: port-level checks for the circle collision unit
// Watches both stream ports and the result encoding over time.
// ============================================================================
`default_nettype none

module ccc_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    input  wire logic                               s_axis_tready,
    input  wire logic [ccc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  wire logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    input  wire logic [ccc_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // accept input whenever the output slot is empty
    a_ready: assert property (@(posedge i_clk)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // no result straight after reset
    a_rst: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid after reset");

    // a miss carries a zero direction
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[48:1] == '0)
        else $error("direction set without a hit");

    // direction stays symmetric: never the most negative code
    a_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[16:1] != 16'h8000 &&
                          m_axis_tdata[32:17] != 16'h8000 &&
                          m_axis_tdata[48:33] != 16'h8000)
        else $error("direction out of range");

endmodule

bind circle_circle_collision_unit ccc_checker u_ccc_checker (.*);

`default_nettype wire

/* tb/circle_circle_collision_unit_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// circle_circle_collision_unit_tb: self-checking bench for the collision unit
// Streams circle pairs through the unit with random gaps and output stalls.
// Each transfer is scored against an exact integer model of the overlap test.
// The same model gives the Q1.15 direction, so every output field is checked.
// ============================================================================
`default_nettype none

module circle_circle_collision_unit_tb;

    localparam int N_RANDOM   = 1500;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYC  = ccc_pkg::LATENCY + 20;

    typedef struct packed {
        logic [ccc_pkg::COORD_W-1:0]  bz;
        logic [ccc_pkg::COORD_W-1:0]  by;
        logic [ccc_pkg::COORD_W-1:0]  bx;
        logic [ccc_pkg::RADIUS_W-1:0] br;
        logic [ccc_pkg::COORD_W-1:0]  az;
        logic [ccc_pkg::COORD_W-1:0]  ay;
        logic [ccc_pkg::COORD_W-1:0]  ax;
        logic [ccc_pkg::RADIUS_W-1:0] ar;
    } t_pair;

    typedef struct {
        logic                      hit;
        logic [ccc_pkg::DIR_W-1:0] dir [3];
    } t_contact;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    // a_x, a_y, a_z, a_radius, b_x, b_y, b_z, b_radius, zero pad
    logic [ccc_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    // hit, dir_x, dir_y, dir_z, zero pad
    logic [ccc_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    logic [ccc_pkg::IN_DATA_W-1:0] pair_queue [$];
    t_contact             contact_queue [$];
    int                   pairs_sent;
    int                   pairs_total;
    int                   contacts_seen;
    int                   hits_seen;
    int                   mismatches;
    int                   idle_cycles;
    int                   send_gap;
    int                   recv_gap;
    bit                   steady_mode;
    bit                   timed_out;

    circle_circle_collision_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Pack one pair into the tdata layout, lowest field first
    function automatic logic [ccc_pkg::IN_DATA_W-1:0] pack_pair(
        logic [31:0] ax, logic [31:0] ay, logic [31:0] az, logic [30:0] ar,
        logic [31:0] bx, logic [31:0] by, logic [31:0] bz, logic [30:0] br);
        logic [ccc_pkg::IN_DATA_W-1:0] v;
        v = '0;
        v[31:0]    = ax;
        v[63:32]   = ay;
        v[95:64]   = az;
        v[126:96]  = ar;
        v[158:127] = bx;
        v[190:159] = by;
        v[222:191] = bz;
        v[253:223] = br;
        return v;
    endfunction

    // Exact overlap test and rounded unit direction from b to a
    function automatic t_contact contact_of(logic [ccc_pkg::IN_DATA_W-1:0] v);
        t_contact         r;
        logic signed [32:0] d [3];
        logic [32:0]      mag [3];
        logic [66:0]      dist_sq;
        logic [31:0]      rsum;
        logic [66:0]      rsum_sq;
        logic [33:0]      root;
        logic [33:0]      trial;
        logic [69:0]      trial_sq;
        logic [63:0]      m;
        for (int i = 0; i < 3; i++) begin
            d[i] = $signed({v[32*i+31], v[32*i +: 32]})
                 - $signed({v[127+32*i+31], v[127+32*i +: 32]});
            mag[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
        end
        dist_sq = 67'(mag[0]) * 67'(mag[0]) + 67'(mag[1]) * 67'(mag[1])
                + 67'(mag[2]) * 67'(mag[2]);
        rsum    = 32'(v[126:96]) + 32'(v[253:223]);
        rsum_sq = 67'(rsum) * 67'(rsum);
        r.hit   = dist_sq < rsum_sq;
        for (int i = 0; i < 3; i++) r.dir[i] = '0;
        if (r.hit && dist_sq != 0) begin
            // bitwise floor square root
            root = '0;
            for (int b = 33; b >= 0; b--) begin
                trial    = root | (34'd1 << b);
                trial_sq = 70'(trial) * 70'(trial);
                if (trial_sq <= 70'(dist_sq)) root = trial;
            end
            for (int i = 0; i < 3; i++) begin
                m = (64'(mag[i]) * 64'd32768 + 64'(root >> 1)) / 64'(root);
                if (m > 64'(ccc_pkg::DIR_MAX)) m = 64'(ccc_pkg::DIR_MAX);
                r.dir[i] = d[i][32] ? ccc_pkg::DIR_W'(-m) : ccc_pkg::DIR_W'(m);
            end
        end
        return r;
    endfunction

    // Mostly short gaps, a few long ones, none while in steady mode
    function automatic int pick_gap(bit steady);
        int p;
        p = $urandom_range(0, 99);
        if (steady || p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver: present queued pairs, insert gaps between transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap      <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                contact_queue.push_back(contact_of(s_axis_tdata));
                pairs_sent <= pairs_sent + 1;
            end
            if (send_gap > 0) begin
                send_gap      <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pair_queue.size() > 0) begin
                s_axis_tdata  <= pair_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                send_gap      <= pick_gap(steady_mode);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: stall the output at random, score each result transfer
    always @(posedge i_clk) begin
        t_contact want;
        logic     got_hit;
        logic [ccc_pkg::DIR_W-1:0] got_dir [3];
        bit       bad;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_gap      <= 0;
            idle_cycles   <= 0;
        end else begin
            if (recv_gap > 0) begin
                recv_gap      <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap(steady_mode);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_axis_tvalid && m_axis_tready) begin
                contacts_seen <= contacts_seen + 1;
                got_hit = m_axis_tdata[0];
                for (int i = 0; i < 3; i++) got_dir[i] = m_axis_tdata[1+16*i +: 16];
                if (got_hit) hits_seen <= hits_seen + 1;
                if (contact_queue.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("ERROR: unexpected result hit=%0b dir=%h %h %h",
                                 got_hit, got_dir[0], got_dir[1], got_dir[2]);
                end else begin
                    want = contact_queue.pop_front();
                    bad  = (want.hit !== got_hit);
                    for (int i = 0; i < 3; i++)
                        if (want.dir[i] !== got_dir[i]) bad = 1'b1;
                    if (bad) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10) begin
                            $write("ERROR: result %0d expected hit=%0b dir=%h %h %h,",
                                   contacts_seen,
                                   want.hit, want.dir[0], want.dir[1], want.dir[2]);
                            $display(" got hit=%0b dir=%h %h %h",
                                     got_hit, got_dir[0], got_dir[1], got_dir[2]);
                        end
                    end
                end
            end
        end
    end

    // Stop if nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n && idle_cycles >= IDLE_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("ERROR: no transfer for %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin
        logic [31:0] ax, ay, az, bx, by, bz;
        logic [30:0] ar, br;
        int          spread;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        pairs_sent    = 0;
        contacts_seen = 0;
        hits_seen     = 0;
        mismatches    = 0;
        idle_cycles   = 0;
        send_gap      = 0;
        recv_gap      = 0;
        steady_mode   = 1'b0;
        timed_out     = 1'b0;

        // all zero, both radii zero: never a hit
        pair_queue.push_back(pack_pair(0, 0, 0, 0, 0, 0, 0, 0));
        // coincident centres with a hit: zero direction
        pair_queue.push_back(pack_pair(32'h0001_0000, 0, 0, 31'h0000_8000,
                                       32'h0001_0000, 0, 0, 0));
        // along each axis: unit component saturates, both signs
        pair_queue.push_back(pack_pair(32'h0001_0000, 0, 0, 31'h0002_0000, 0, 0, 0, 0));
        pair_queue.push_back(pack_pair(0, 32'hFFFF_0000, 0, 31'h0002_0000, 0, 0, 0, 0));
        pair_queue.push_back(pack_pair(0, 0, 32'h0000_0003, 0, 0, 0, 0, 31'd4));
        pair_queue.push_back(pack_pair(0, 0, 0, 0, 0, 0, 32'h0000_0005, 31'd9));
        // touching exactly: no hit; radius one larger: hit
        pair_queue.push_back(pack_pair(32'd3, 32'd4, 0, 31'd2, 0, 0, 0, 31'd3));
        pair_queue.push_back(pack_pair(32'd3, 32'd4, 0, 31'd2, 0, 0, 0, 31'd4));
        // extreme coordinates, largest radii
        pair_queue.push_back(pack_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                       31'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                       32'h8000_0000, 31'h7FFF_FFFF));
        pair_queue.push_back(pack_pair(32'h8000_0000, 0, 0, 31'h7FFF_FFFF,
                                       32'h7FFF_FFFF, 0, 0, 31'h7FFF_FFFF));
        pair_queue.push_back(pack_pair(32'h7FFF_FFFF, 32'h8000_0000, 0, 31'h7FFF_FFFF,
                                       0, 0, 0, 31'h7FFF_FFFF));
        pair_queue.push_back(pack_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                       31'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                       32'h8000_0000, 31'h7FFF_FFFF));
        // diagonal and mixed-sign separations
        pair_queue.push_back(pack_pair(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                                       31'h0004_0000, 0, 0, 0, 0));
        pair_queue.push_back(pack_pair(32'hFFFF_0000, 32'h0002_0000, 32'hFFFD_0000,
                                       31'h0003_0000, 0, 0, 0, 31'h0002_0000));
        pair_queue.push_back(pack_pair(32'd1, 32'd1, 32'd1, 31'd2, 0, 0, 0, 0));

        // random pairs: mostly near each other so hits are common
        for (int n = 0; n < N_RANDOM; n++) begin
            ax = $urandom; ay = $urandom; az = $urandom;
            ar = 31'($urandom); br = 31'($urandom);
            if ($urandom_range(0, 3) == 0) begin
                bx = $urandom; by = $urandom; bz = $urandom;
            end else begin
                spread = $urandom_range(1, 30);
                bx = ax + 32'($signed($urandom) >>> spread);
                by = ay + 32'($signed($urandom) >>> spread);
                bz = az + 32'($signed($urandom) >>> spread);
                if ($urandom_range(0, 9) == 0) begin
                    by = ay; bz = az;
                end
                ar = ar >> $urandom_range(spread > 1 ? spread - 1 : 0, 30);
                br = br >> $urandom_range(spread > 1 ? spread - 1 : 0, 30);
            end
            pair_queue.push_back(pack_pair(ax, ay, az, ar, bx, by, bz, br));
        end
        pairs_total = pair_queue.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // alternate between idle-heavy and back-to-back stretches
        while (pairs_sent < pairs_total) begin
            repeat (200) @(posedge i_clk);
            steady_mode = ($urandom_range(0, 2) == 0);
        end
        steady_mode = 1'b0;
        while (contact_queue.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("Sent %0d circle pairs, checked %0d results, %0d of them hits.",
                 pairs_sent, contacts_seen, hits_seen);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0 && contact_queue.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* circle_circle_collision_unit.f */
rtl/ccc_pkg.sv
rtl/ccc_front.sv
rtl/ccc_sqrt.sv
rtl/ccc_div.sv
rtl/circle_circle_collision_unit.sv
rtl/ccc_checker.sv
tb/circle_circle_collision_unit_tb.sv
